// ===== rtl/pfa_pkg.sv =====
// Shared types and constants of the page-frame allocator.
// No dependencies; every other file imports it.
package pfa_pkg;

	localparam int FREE_DEPTH_DEF = 256;
	localparam int PAGE_BITS_DEF  = 20;
	localparam int COUNT_W        = 16;
	localparam int STATUS_W       = 2;

	typedef enum logic {
		FN_ALLOC = 1'b0,
		FN_FREE  = 1'b1
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_OOM  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic {
		REG_START = 1'b0,
		REG_LIMIT = 1'b1
	} reg_idx_t;

endpackage

// ===== rtl/pfa_req_if.sv =====
// Request channel of the page-frame allocator: valid/ready plus one request item.
// Depends on pfa_pkg.
interface pfa_req_if import pfa_pkg::*; #(
	parameter int PAGE_BITS = PAGE_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [COUNT_W-1:0]   num_pages;
	logic [PAGE_BITS-1:0] free_addr;

	modport source (output valid, func, num_pages, free_addr, input ready);
	modport sink   (input valid, func, num_pages, free_addr, output ready);
endinterface

// ===== rtl/pfa_rsp_if.sv =====
// Result channel of the page-frame allocator: valid/ready plus one result item.
// Depends on pfa_pkg.
interface pfa_rsp_if import pfa_pkg::*; #(
	parameter int PAGE_BITS = PAGE_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] alloc_addr;
	logic [STATUS_W-1:0]  status;

	modport source (output valid, alloc_addr, status, input ready);
	modport sink   (input valid, alloc_addr, status, output ready);
endinterface

// ===== rtl/pfa_free_ram.sv =====
// Free-list storage: one write port, one read port, registered read data.
// Depends on pfa_pkg.
module pfa_free_ram import pfa_pkg::*; #(
	parameter int DEPTH = FREE_DEPTH_DEF,
	parameter int WIDTH = PAGE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/pfa_bump.sv =====
// Bump pointer and pool registers: out-of-memory check and pointer advance.
// Depends on pfa_pkg.
module pfa_bump import pfa_pkg::*; #(
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_idx,
	input  logic [PAGE_BITS-1:0] cfg_data,
	input  logic                 take,
	input  logic [COUNT_W-1:0]   num_pages,
	output logic [PAGE_BITS-1:0] base,
	output logic                 oom
);
	localparam int SW = ((PAGE_BITS > COUNT_W) ? PAGE_BITS : COUNT_W) + 1;

	logic [PAGE_BITS-1:0] bump_q;
	logic [PAGE_BITS-1:0] limit_q;
	logic [SW-1:0]        next_page;

	assign next_page = SW'(bump_q) + SW'(num_pages);
	assign oom       = next_page > SW'(limit_q);
	assign base      = bump_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_q  <= '0;
			limit_q <= '1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_START: bump_q  <= cfg_data;
				REG_LIMIT: limit_q <= cfg_data;
				default:   ;
			endcase
		end else if (take) begin
			// advance on take; the caller raises take only when within the limit
			bump_q <= next_page[PAGE_BITS-1:0];
		end
	end
endmodule

// ===== rtl/page_frame_allocator_unit.sv =====
// Page-frame allocator top level: request decode, free-list pointers, result pipeline.
// Depends on pfa_pkg, pfa_req_if, pfa_rsp_if, pfa_free_ram and pfa_bump.
//
// Usage:
//   req carries one request item: func (allocate or free), num_pages and
//   free_addr. rsp returns exactly one result item per request, in order:
//   alloc_addr and status (ok, out of memory, free list full).
//   Both channels move an item when valid and ready are high at a clock edge.
// Pipeline:
//   A result passes the middle stage, which waits for the free-list memory
//   read, and then the output register. Every decision (pop, push, bump
//   advance) is made as the request is taken, so one item per cycle is
//   sustained while rsp is ready; the free-list memory read is the only
//   access in flight, and its data is used as the middle stage advances.
// Stalls:
//   When rsp is not ready, the output register holds its item and the
//   middle stage holds the next; req.ready drops once both are full.
// Reset:
//   arst_n clears the pipeline, the free-list pointers and count, loads the
//   bump pointer with 0 and the limit with all ones. The free-list memory is
//   not cleared; only entries that were pushed are ever read.
// Configuration:
//   cfg_we/cfg_idx/cfg_data write pool start (reloads the bump pointer) or
//   pool limit, and are expected only while no item is in flight.
module page_frame_allocator_unit import pfa_pkg::*; #(
	parameter int FREE_DEPTH = FREE_DEPTH_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_idx,
	input  logic [PAGE_BITS-1:0] cfg_data,
	pfa_req_if.sink              req,
	pfa_rsp_if.source            rsp
);
	localparam int IW = $clog2(FREE_DEPTH);
	localparam int CW = $clog2(FREE_DEPTH + 1);

	// free-list ring pointers and fill count
	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [CW-1:0] count_q;

	// middle stage: waits for the memory read data
	logic                 valid_s1;
	logic                 from_ram_s1;
	logic [PAGE_BITS-1:0] addr_s1;
	status_t              status_s1;

	// output register
	logic                 out_valid_q;
	logic [PAGE_BITS-1:0] out_addr_q;
	status_t              out_status_q;

	logic                 accept;
	logic                 is_alloc;
	logic                 fl_empty;
	logic                 list_full;
	logic                 pop;
	logic                 push;
	logic                 drop_full;
	logic                 bump_oom;
	logic                 bump_take;
	logic [PAGE_BITS-1:0] bump_base;
	logic [PAGE_BITS-1:0] ram_rdata;
	logic                 s1_go;

	pfa_bump #(
		.PAGE_BITS (PAGE_BITS)
	) u_bump (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.take       (bump_take),
		.num_pages  (req.num_pages),
		.base       (bump_base),
		.oom        (bump_oom)
	);

	pfa_free_ram #(
		.DEPTH (FREE_DEPTH),
		.WIDTH (PAGE_BITS)
	) u_free_ram (
		.clk   (clk),
		.we    (push),
		.waddr (tail_q),
		.wdata (req.free_addr),
		.re    (pop),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// Decode the request as it is taken. A pop and a push never share a
	// cycle, and a pushed entry is read at the earliest by a later request,
	// after the write has landed, so no forwarding is needed.
	always_comb begin
		accept     = req.valid && req.ready;
		is_alloc   = func_t'(req.func) == FN_ALLOC;
		fl_empty   = count_q == '0;
		list_full  = count_q >= CW'(FREE_DEPTH);
		pop        = accept && is_alloc && (req.num_pages == COUNT_W'(1)) && !fl_empty;
		bump_take  = accept && is_alloc && !pop && !bump_oom;
		push       = accept && !is_alloc && (req.free_addr != '0) && !list_full;
		drop_full  = !is_alloc && (req.free_addr != '0) && list_full;
	end

	// advance the middle stage when the output register is free or draining
	assign s1_go     = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= (head_q == IW'(FREE_DEPTH - 1)) ? '0 : head_q + IW'(1);
			end
			if (push) begin
				tail_q <= (tail_q == IW'(FREE_DEPTH - 1)) ? '0 : tail_q + IW'(1);
			end
			if (pop) begin
				count_q <= count_q - CW'(1);
			end else if (push) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			from_ram_s1 <= pop;
			addr_s1     <= bump_take ? bump_base : '0;
			if (is_alloc && !pop && bump_oom) begin
				status_s1 <= ST_OOM;
			end else if (drop_full) begin
				status_s1 <= ST_FULL;
			end else begin
				status_s1 <= ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// merge the memory read data for a free-list pop
	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_addr_q   <= from_ram_s1 ? ram_rdata : addr_s1;
			out_status_q <= status_s1;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.alloc_addr = out_addr_q;
	assign rsp.status     = out_status_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(FREE_DEPTH))
		else $error("free-list count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fl_empty && !push)
		else $error("pop from empty list or pop with push");

	a_err_null: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_OK) |-> out_addr_q == '0)
		else $error("error result carries a page");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |=> valid_s1 && $stable(addr_s1) &&
			(!from_ram_s1 || $stable(ram_rdata)))
		else $error("middle stage lost its item");
`endif
endmodule

// ===== sim/page_frame_allocator_unit_tb.sv =====
// Testbench of the page-frame allocator: directed and random request streams,
// checked item by item against an in-bench model of the free list and bump pointer.
// Depends on pfa_pkg, pfa_req_if, pfa_rsp_if and page_frame_allocator_unit.
module page_frame_allocator_unit_tb import pfa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGE_W       = PAGE_BITS_DEF;
	localparam int FREE_DEPTH   = FREE_DEPTH_DEF;
	localparam int CYCLE_LIMIT  = 500000;
	// extra wait after the last owed result has come back
	localparam int DRAIN_CYCLES = 8;

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct {
		page_t   addr;
		status_t status;
	} alloc_result_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     cfg_we;
	reg_idx_t cfg_idx;
	page_t    cfg_data;

	pfa_req_if #(.PAGE_BITS(PAGE_W)) req_ch ();
	pfa_rsp_if #(.PAGE_BITS(PAGE_W)) rsp_ch ();

	page_frame_allocator_unit #(
		.FREE_DEPTH(FREE_DEPTH),
		.PAGE_BITS (PAGE_W)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Allocator state as the block should hold it, plus the results still owed.
	page_t         pool_start = '0;
	page_t         pool_limit = '1;
	page_t         bump_ptr   = '0;
	page_t         freed_pages[$];
	alloc_result_t owed_results[$];
	int            errors = 0;

	// Idling controls: switch sender gaps and receiver stalls on or off,
	// and request a long receiver hold-off.
	bit tx_gaps_on   = 1'b1;
	bit rx_stalls_on = 1'b1;
	int hold_request = 0;
	int hold_left    = 0;
	int stall_left   = 0;
	int cycles       = 0;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Apply one request to the allocator state and return the result it owes.
	function automatic alloc_result_t serve_request(func_t fn, count_t cnt, page_t page);
		alloc_result_t res;
		logic [PAGE_W:0] next;
		res.addr   = '0;
		res.status = ST_OK;
		if (fn == FN_ALLOC) begin
			// single pages come from the free list first; any other count bumps
			if (cnt == count_t'(1) && freed_pages.size() != 0) begin
				res.addr = freed_pages.pop_front();
			end else begin
				next = {1'b0, bump_ptr} + (PAGE_W + 1)'(cnt);
				if (next > {1'b0, pool_limit}) begin
					res.status = ST_OOM;
				end else begin
					res.addr = bump_ptr;
					bump_ptr = next[PAGE_W-1:0];
				end
			end
		end else if (page != '0) begin
			// drop the page when the list is full, queue it otherwise
			if (freed_pages.size() >= FREE_DEPTH)
				res.status = ST_FULL;
			else
				freed_pages.push_back(page);
		end
		return res;
	endfunction

	// Check each result item against the oldest owed one, then record the
	// request taken at the same edge. A result reaches rsp only through the
	// middle stage and output register, so the order of the two steps never matters.
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (owed_results.size() == 0) begin
					$display("%0t: result with none owed: addr %h status %0d",
						$time, rsp_ch.alloc_addr, rsp_ch.status);
					errors++;
				end else begin
					want = owed_results.pop_front();
					if (rsp_ch.alloc_addr !== want.addr) begin
						$display("%0t: alloc_addr expected %h, got %h",
							$time, want.addr, rsp_ch.alloc_addr);
						errors++;
					end
					if (rsp_ch.status !== want.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, rsp_ch.status);
						errors++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready)
				owed_results.push_back(serve_request(func_t'(req_ch.func),
					req_ch.num_pages, req_ch.free_addr));
		end
	end

	// Receiver: a requested hold-off wins, then random stalls, else accept.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left--;
		end else if (stall_left != 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (rx_stalls_on && $urandom_range(0, 4) == 0)
				stall_left = pick_gap() + 1;
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results owed",
				$time, cycles, owed_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one request item after an optional gap and hold it until taken.
	// Valid is left high afterwards; a gap in the next call or a drain lowers it.
	task automatic send_item(func_t fn, count_t cnt, page_t page);
		int gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid     <= 1'b1;
		req_ch.func      <= fn;
		req_ch.num_pages <= cnt;
		req_ch.free_addr <= page;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Stop offering and wait until every owed result has come back.
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register while the block is idle and mirror it in the model.
	task automatic write_reg(reg_idx_t idx, page_t value);
		drain();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_START) begin
			pool_start = value;
			bump_ptr   = value;
		end else begin
			pool_limit = value;
		end
	endtask

	function automatic count_t random_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return count_t'(1);
		if (r < 62)
			return count_t'(0);
		if (r < 90)
			return count_t'($urandom_range(2, 32));
		if (r < 96)
			return count_t'($urandom_range(33, 4096));
		return count_t'($urandom);
	endfunction

	function automatic page_t random_page();
		if ($urandom_range(0, 99) < 5)
			return '0;
		return page_t'($urandom);
	endfunction

	// Mixed traffic; the unused field of each item is random as well.
	task automatic run_traffic(int n, int free_pct);
		repeat (n) begin
			if ($urandom_range(0, 99) < free_pct)
				send_item(FN_FREE, count_t'($urandom), random_page());
			else
				send_item(FN_ALLOC, random_count(), page_t'($urandom));
		end
	endtask

	// Bump allocation from the reset pool, which starts at page zero.
	task automatic test_bump_alloc();
		send_item(FN_ALLOC, 16'd1, '0);      // pool at page zero: addr 0, ok
		send_item(FN_ALLOC, 16'd0, '1);      // zero count: pointer held
		send_item(FN_ALLOC, 16'hFFFF, '0);   // largest count
		send_item(FN_ALLOC, 16'd3, '0);
		send_item(FN_FREE, 16'hFFFF, '0);    // null free: ignored
	endtask

	// Free list order, repeated free, and counts that bypass the list.
	task automatic test_free_list();
		send_item(FN_FREE, 16'd0, '1);
		send_item(FN_FREE, 16'd0, page_t'(1));
		send_item(FN_FREE, 16'd0, page_t'(1));   // same page queued twice
		send_item(FN_ALLOC, 16'd0, '0);          // zero count never pops
		send_item(FN_ALLOC, 16'd2, '0);          // multi-page never pops
		repeat (4) send_item(FN_ALLOC, 16'd1, '0);
	endtask

	// Out of memory at the limit, pointer past the limit, and extreme settings.
	task automatic test_pool_limits();
		write_reg(REG_START, page_t'(100));
		write_reg(REG_LIMIT, page_t'(110));
		send_item(FN_ALLOC, 16'd10, '0);
		send_item(FN_ALLOC, 16'd1, '0);          // one past the limit
		send_item(FN_ALLOC, 16'd0, '0);          // at the limit exactly
		write_reg(REG_START, page_t'(200));
		send_item(FN_ALLOC, 16'd0, '0);          // zero count past the limit
		write_reg(REG_START, '0);
		write_reg(REG_LIMIT, '0);
		send_item(FN_ALLOC, 16'd0, '0);
		send_item(FN_ALLOC, 16'd1, '0);
		write_reg(REG_START, '1);
		write_reg(REG_LIMIT, '1);
		send_item(FN_ALLOC, 16'd0, '0);
		send_item(FN_ALLOC, 16'd1, '0);
		send_item(FN_ALLOC, 16'hFFFF, '0);
	endtask

	// Hold the receiver off while the sender keeps offering back to back,
	// so the pipeline fills and ready drops on the request side.
	task automatic test_back_pressure();
		write_reg(REG_START, page_t'(1));
		tx_gaps_on   = 1'b0;
		hold_request = 60;
		run_traffic(24, 50);
		tx_gaps_on = 1'b1;
	endtask

	// Wide pool: mostly successful allocations with a busy free list.
	task automatic test_random_wide();
		write_reg(REG_LIMIT, '1);
		write_reg(REG_START, page_t'(1));
		run_traffic(250, 50);
	endtask

	// Narrow pool: out-of-memory results are frequent.
	task automatic test_random_tight();
		page_t base;
		base = page_t'($urandom_range(1, 20'hF0000));
		write_reg(REG_START, base);
		write_reg(REG_LIMIT, base + page_t'($urandom_range(0, 2000)));
		run_traffic(200, 40);
	endtask

	// Push the free list over its depth, then drain part of it.
	task automatic test_free_list_fill();
		write_reg(REG_LIMIT, '1);
		write_reg(REG_START, '0);
		run_traffic(330, 95);
		run_traffic(120, 5);
	endtask

	// Full rate on both sides, no idling at all.
	task automatic test_random_no_idle();
		write_reg(REG_START, page_t'($urandom_range(0, 1000)));
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		run_traffic(200, 50);
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	// Start above the limit: only single pages from the free list succeed.
	task automatic test_start_past_limit();
		page_t base;
		base = page_t'($urandom_range(20'h80000, 20'hFFFFF));
		write_reg(REG_START, base);
		write_reg(REG_LIMIT, page_t'($urandom_range(0, base - 1)));
		run_traffic(100, 45);
	endtask

	task automatic finish_run();
		drain();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_idx          = REG_START;
		cfg_data         = '0;
		req_ch.valid     = 1'b0;
		req_ch.func      = FN_ALLOC;
		req_ch.num_pages = '0;
		req_ch.free_addr = '0;
		rsp_ch.ready     = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_bump_alloc();
		test_free_list();
		test_pool_limits();
		test_back_pressure();
		test_random_wide();
		test_random_tight();
		test_free_list_fill();
		test_random_no_idle();
		test_start_past_limit();
		finish_run();
	end

endmodule

// ===== filelist.f =====
rtl/pfa_pkg.sv
rtl/pfa_req_if.sv
rtl/pfa_rsp_if.sv
rtl/pfa_free_ram.sv
rtl/pfa_bump.sv
rtl/page_frame_allocator_unit.sv
sim/page_frame_allocator_unit_tb.sv
